### sv/rnp_pkg.sv
package rnp_pkg;

    // Largest NAL unit size taken as it is; larger sizes are clamped
    localparam int unsigned MAX_NAL_BYTES = 16383;

    // Payload limit clamp range and reset value
    localparam logic [10:0] PAYLOAD_MIN   = 11'd300;
    localparam logic [10:0] PAYLOAD_MAX   = 11'd1500;
    localparam logic [10:0] PAYLOAD_RESET = 11'd1400;

    // Configuration register indexes
    localparam logic [1:0] CFG_CODEC       = 2'd0;
    localparam logic [1:0] CFG_SINGLE_MODE = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    // Packet kinds
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_AGGR   = 2'd1;
    localparam logic [1:0] KIND_FRAG   = 2'd2;

    // Payload header bytes
    localparam logic [7:0] STAP_A_TYPE    = 8'd24;
    localparam logic [7:0] AP_TYPE        = 8'd48 << 1;
    localparam logic [7:0] FU_A_TYPE      = 8'd28;
    localparam logic [7:0] HEVC_FU_TYPE   = 8'd49 << 1;
    localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
    localparam logic [7:0] NRI_MASK       = 8'h60;
    localparam logic [7:0] HEVC_TYPE_MASK = 8'h3F;
    localparam logic [7:0] FU_START       = 8'd1 << 7;
    localparam logic [7:0] FU_END         = 8'd1 << 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_PLACE,
        ST_SINGLE,
        ST_FRAG,
        ST_FLUSH_LAST
    } ctrl_state_t;

    // Which packet the datapath builds into the output register
    typedef enum logic [1:0] {
        EMIT_AGGR,
        EMIT_SINGLE,
        EMIT_FRAG
    } emit_sel_t;

    typedef struct packed {
        logic      load_item;
        logic      clear_buf;
        logic      add_buf;
        logic      frag_step;
        logic      emit;
        emit_sel_t emit_sel;
        logic      marker;
        logic      last_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic big;
        logic drop;
        logic flush_needed;
        logic fits_add;
        logic fits_empty;
        logic buf_empty;
        logic frag_more;
        logic last;
    } dp_status_t;

endpackage

### sv/rnp_nal_if.sv
interface rnp_nal_if;
    logic        valid;
    logic        ready;
    logic [13:0] nal_size;
    logic [7:0]  header_byte0;
    logic [7:0]  header_byte1;
    logic        last_in_frame;

    modport source (
        output valid,
        output nal_size,
        output header_byte0,
        output header_byte1,
        output last_in_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  nal_size,
        input  header_byte0,
        input  header_byte1,
        input  last_in_frame,
        output ready
    );
endinterface

### sv/rnp_pkt_if.sv
interface rnp_pkt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  packet_kind;
    logic [10:0] payload_length;
    logic [8:0]  unit_count;
    logic [13:0] source_offset;
    logic [7:0]  prefix_byte0;
    logic [7:0]  prefix_byte1;
    logic [7:0]  prefix_byte2;
    logic        marker;
    logic        last_result;

    modport source (
        output valid,
        output packet_kind,
        output payload_length,
        output unit_count,
        output source_offset,
        output prefix_byte0,
        output prefix_byte1,
        output prefix_byte2,
        output marker,
        output last_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  packet_kind,
        input  payload_length,
        input  unit_count,
        input  source_offset,
        input  prefix_byte0,
        input  prefix_byte1,
        input  prefix_byte2,
        input  marker,
        input  last_result,
        output ready
    );
endinterface

### sv/rnp_ctrl.sv
module rnp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rnp_pkg::dp_status_t status,
    output rnp_pkg::ctrl_cmd_t  cmd
);
    import rnp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.emit_sel    = EMIT_AGGR;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_FLUSH;
                end
            end

            // Flush ahead of the unit if it will not join the aggregate
            ST_FLUSH:
            begin
                if ((status.big || status.flush_needed) && !status.buf_empty)
                begin
                    if (status.slot_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_sel    = EMIT_AGGR;
                        cmd.clear_buf   = 1'b1;
                        cmd.last_result = (status.big && status.drop) ||
                                          (!status.big && status.fits_empty && !status.last);
                        if (status.big)
                        begin
                            state_next = status.drop ? ST_IDLE : ST_FRAG;
                        end
                        else
                        begin
                            state_next = ST_PLACE;
                        end
                    end
                end
                else if (status.big)
                begin
                    state_next = status.drop ? ST_IDLE : ST_FRAG;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end

            // Join the aggregate, or flush it and send the unit alone
            ST_PLACE:
            begin
                if (status.fits_add)
                begin
                    cmd.add_buf = 1'b1;
                    state_next  = status.last ? ST_FLUSH_LAST : ST_IDLE;
                end
                else if (!status.buf_empty)
                begin
                    if (status.slot_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = EMIT_AGGR;
                        cmd.clear_buf = 1'b1;
                        state_next    = ST_SINGLE;
                    end
                end
                else
                begin
                    state_next = ST_SINGLE;
                end
            end

            ST_SINGLE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EMIT_SINGLE;
                    cmd.marker      = status.last;
                    cmd.last_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            // One fragment per word slot
            ST_FRAG:
            begin
                if (status.slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EMIT_FRAG;
                    cmd.frag_step   = 1'b1;
                    cmd.marker      = status.last && !status.frag_more;
                    cmd.last_result = !status.frag_more;
                    if (!status.frag_more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // End of access unit: flush with marker
            ST_FLUSH_LAST:
            begin
                if (status.buf_empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EMIT_AGGR;
                    cmd.clear_buf   = 1'b1;
                    cmd.marker      = 1'b1;
                    cmd.last_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/rnp_datapath.sv
module rnp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_data,
    input  logic [13:0]         nal_size,
    input  logic [7:0]          header_byte0,
    input  logic                last_in_frame,
    input  rnp_pkg::ctrl_cmd_t  cmd,
    output rnp_pkg::dp_status_t status,
    rnp_pkt_if.source           pkt
);
    import rnp_pkg::*;

    logic        codec_reg;
    logic        single_mode_reg;
    logic [10:0] max_payload_reg;

    logic [13:0] size_reg;
    logic [7:0]  h0_reg;
    logic        last_reg;

    logic [13:0] off_reg;
    logic [13:0] rem_reg;
    logic        start_reg;

    logic [10:0] bb_reg;
    logic [10:0] bb_next;
    logic [8:0]  bu_reg;
    logic [8:0]  bu_next;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [10:0] len_reg;
    logic [10:0] len_next;
    logic [8:0]  units_reg;
    logic [8:0]  units_next;
    logic [13:0] src_off_reg;
    logic [13:0] src_off_next;
    logic [7:0]  p0_reg;
    logic [7:0]  p0_next;
    logic [7:0]  p1_reg;
    logic [7:0]  p1_next;
    logic [7:0]  p2_reg;
    logic [7:0]  p2_next;
    logic        marker_reg;
    logic        last_result_reg;

    logic [10:0] maxp;
    logic [15:0] maxp16;
    logic [1:0]  hdr_len;
    logic [1:0]  fu_hdr;
    logic [2:0]  strip;
    logic        skip;
    logic [13:0] size_sat;
    logic [10:0] chunk;
    logic [15:0] sum_a;
    logic [15:0] sum_b;
    logic [15:0] sum_e;
    logic [7:0]  fu_flags;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_reg       <= 1'b0;
            single_mode_reg <= 1'b0;
            max_payload_reg <= PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CODEC:       codec_reg       <= cfg_data[0];
                CFG_SINGLE_MODE: single_mode_reg <= cfg_data[0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamped limit and codec dependent header sizes
    always_comb
    begin
        if (max_payload_reg < PAYLOAD_MIN)
        begin
            maxp = PAYLOAD_MIN;
        end
        else if (max_payload_reg > PAYLOAD_MAX)
        begin
            maxp = PAYLOAD_MAX;
        end
        else
        begin
            maxp = max_payload_reg;
        end
    end

    assign maxp16   = {5'b0, maxp};
    assign hdr_len  = codec_reg ? 2'd2 : 2'd1;
    assign fu_hdr   = codec_reg ? 2'd3 : 2'd2;
    assign strip    = codec_reg ? 3'd4 : 3'd3;
    assign skip     = !codec_reg && single_mode_reg;
    assign size_sat = (nal_size > 14'(MAX_NAL_BYTES)) ? 14'(MAX_NAL_BYTES) : nal_size;
    assign chunk    = maxp - {9'b0, fu_hdr};

    // Latched unit descriptor
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            size_reg <= size_sat;
            h0_reg   <= header_byte0;
            last_reg <= last_in_frame;
        end
    end

    // Fragment walk: offset, bytes left, start flag
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            off_reg   <= {12'b0, hdr_len};
            rem_reg   <= size_sat - {12'b0, hdr_len};
            start_reg <= 1'b1;
        end
        else if (cmd.frag_step)
        begin
            off_reg   <= off_reg + {3'b0, chunk};
            rem_reg   <= rem_reg - {3'b0, chunk};
            start_reg <= 1'b0;
        end
    end

    // Aggregate occupancy
    always_comb
    begin
        bb_next = bb_reg;
        bu_next = bu_reg;
        if (cmd.clear_buf)
        begin
            bb_next = '0;
            bu_next = '0;
        end
        else if (cmd.add_buf)
        begin
            bb_next = ((bb_reg == 11'd0) ? {9'b0, hdr_len} : bb_reg) + 11'd2 + size_reg[10:0];
            bu_next = (bu_reg == 9'd511) ? bu_reg : bu_reg + 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bb_reg <= '0;
            bu_reg <= '0;
        end
        else
        begin
            bb_reg <= bb_next;
            bu_reg <= bu_next;
        end
    end

    // Fit checks
    assign sum_a = {5'b0, bb_reg} + 16'd2 + {2'b0, size_reg};
    assign sum_b = sum_a + {14'b0, hdr_len};
    assign sum_e = 16'd2 + {14'b0, hdr_len} + {2'b0, size_reg};

    always_comb
    begin
        status.slot_free    = !valid_reg || pkt.ready;
        status.big          = size_reg > {3'b0, maxp};
        status.drop         = skip;
        status.flush_needed = sum_a > maxp16;
        status.fits_add     = (sum_b <= maxp16) && !skip;
        status.fits_empty   = (sum_e <= maxp16) && !skip;
        status.buf_empty    = (bb_reg == 11'd0);
        status.frag_more    = rem_reg > {3'b0, chunk};
        status.last         = last_reg;
    end

    // Packet word builder
    assign fu_flags = (start_reg ? FU_START : 8'h00) | (status.frag_more ? 8'h00 : FU_END);

    always_comb
    begin
        kind_next    = KIND_SINGLE;
        len_next     = '0;
        units_next   = '0;
        src_off_next = '0;
        p0_next      = '0;
        p1_next      = '0;
        p2_next      = '0;

        case (cmd.emit_sel)
            EMIT_AGGR:
            begin
                if (bu_reg == 9'd1)
                begin
                    // lone unit goes out as a single NAL, aggregation headers stripped
                    len_next = (bb_reg > {8'b0, strip}) ? bb_reg - {8'b0, strip} : 11'd0;
                end
                else
                begin
                    kind_next  = KIND_AGGR;
                    len_next   = bb_reg;
                    units_next = bu_reg;
                    p0_next    = codec_reg ? AP_TYPE : STAP_A_TYPE;
                    p1_next    = codec_reg ? 8'd1 : 8'd0;
                end
            end

            EMIT_SINGLE:
            begin
                len_next = size_reg[10:0];
            end

            EMIT_FRAG:
            begin
                kind_next    = KIND_FRAG;
                len_next     = status.frag_more ? maxp : rem_reg[10:0] + {9'b0, fu_hdr};
                src_off_next = off_reg;
                if (codec_reg)
                begin
                    p0_next = HEVC_FU_TYPE;
                    p1_next = 8'd1;
                    p2_next = ({1'b0, h0_reg[7:1]} & HEVC_TYPE_MASK) | fu_flags;
                end
                else
                begin
                    p0_next = FU_A_TYPE | (h0_reg & NRI_MASK);
                    p1_next = (h0_reg & H264_TYPE_MASK) | fu_flags;
                end
            end

            default:
            begin
                kind_next = KIND_SINGLE;
            end
        endcase
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (pkt.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg        <= kind_next;
            len_reg         <= len_next;
            units_reg       <= units_next;
            src_off_reg     <= src_off_next;
            p0_reg          <= p0_next;
            p1_reg          <= p1_next;
            p2_reg          <= p2_next;
            marker_reg      <= cmd.marker;
            last_result_reg <= cmd.last_result;
        end
    end

    assign pkt.valid          = valid_reg;
    assign pkt.packet_kind    = kind_reg;
    assign pkt.payload_length = len_reg;
    assign pkt.unit_count     = units_reg;
    assign pkt.source_offset  = src_off_reg;
    assign pkt.prefix_byte0   = p0_reg;
    assign pkt.prefix_byte1   = p1_reg;
    assign pkt.prefix_byte2   = p2_reg;
    assign pkt.marker         = marker_reg;
    assign pkt.last_result    = last_result_reg;

endmodule

### sv/rtp_nal_packetizer_top.sv
// RTP packetizer for H.264 and HEVC working on NAL unit descriptors: each word
// on the nal channel describes one unit, each word on the pkt channel one RTP
// packet (single NAL, STAP-A/AP aggregate, or FU fragment), with last_result
// set on the final packet a unit causes; a unit may cause no packet at all.
// One unit is handled at a time. Acceptance comes first, then the decision on
// flushing the aggregate (the flush goes out in that step), then placing a
// unit that fits, then a lone single NAL, the closing flush of the frame or
// each fragment goes out through the output register; each step that emits
// waits while the pkt side stalls.
// The fragment walk is a single offset/remainder register pair stepped once
// per fragment. A new unit is taken while the last packet still waits in the
// output register. Configuration is to be written only between units; the
// block itself does not enforce this.
module rtp_nal_packetizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    rnp_nal_if.sink     nal,
    rnp_pkt_if.source   pkt
);
    import rnp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    assign nal.ready = in_ready;

    rnp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (nal.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rnp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .nal_size      (nal.nal_size),
        .header_byte0  (nal.header_byte0),
        .last_in_frame (nal.last_in_frame),
        .cmd           (cmd),
        .status        (status),
        .pkt           (pkt)
    );

`ifndef SYNTH
    // A unit is worked on alone: no second acceptance straight after one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        nal.valid && nal.ready |=> !nal.ready)
        else $error("unit accepted while previous unit still in progress");

    // The marker only ever sits on the final packet of a unit
    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.marker |-> pkt.last_result)
        else $error("marker on a packet that is not the last of its unit");

    // An aggregate always carries at least two units
    a_aggr_units: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.packet_kind == KIND_AGGR |-> pkt.unit_count >= 9'd2)
        else $error("aggregation packet with fewer than two units");

    // No packet exceeds the largest allowed payload
    a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid |-> pkt.payload_length <= PAYLOAD_MAX)
        else $error("payload length beyond limit");
`endif

endmodule

### sim/tb_rtp_nal_packetizer_top.sv
`timescale 1ns / 100ps

module tb_rtp_nal_packetizer_top;
    import rnp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 240;
    localparam int FILL_ITEMS    = 40;
    localparam int MAX_REPORTS   = 10;

    // Second payload header byte of HEVC AP and FU (layer 0, TID 1)
    localparam logic [7:0] HEVC_PH_BYTE1 = 8'd1;

    typedef struct packed {
        logic [13:0] nal_size;
        logic [7:0]  header_byte0;
        logic [7:0]  header_byte1;
        logic        last_in_frame;
    } nal_word_t;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic [10:0] payload_length;
        logic [8:0]  unit_count;
        logic [13:0] source_offset;
        logic [7:0]  prefix_byte0;
        logic [7:0]  prefix_byte1;
        logic [7:0]  prefix_byte2;
        logic        marker;
        logic        last_result;
    } pkt_word_t;

    typedef enum logic {
        ROW_NAL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cfg_index;
        logic [10:0] cfg_data;
        nal_word_t   nal;
        logic        typed;
        pkt_word_t   typed_pkt;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    rnp_nal_if nal_ch ();
    rnp_pkt_if pkt_ch ();

    rtp_nal_packetizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .nal       (nal_ch),
        .pkt       (pkt_ch)
    );

    // Shadow of the configuration and of the aggregation buffer
    logic        cfg_codec;
    logic        cfg_single;
    logic [10:0] cfg_maxp;
    int          agg_bytes;
    int          agg_units;

    pkt_word_t   pkt_batch[$];
    pkt_word_t   pkt_expected[$];
    stim_row_t   dir_rows[$];

    int          mismatch_count;
    int          cycle_count;
    int          burst_left;
    bit          hold_req;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Packetizer prediction
    // ---------------------------------------------------------------

    // Payload limit as the block uses it: clamped into 300..1500
    function automatic int payload_limit();
        int lim;
        lim = cfg_maxp;
        if (lim < PAYLOAD_MIN)
            lim = PAYLOAD_MIN;
        if (lim > PAYLOAD_MAX)
            lim = PAYLOAD_MAX;
        return lim;
    endfunction

    function automatic void push_pkt(logic [1:0] kind, int len, int units, int offset,
                                     logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                                     logic mk);
        pkt_word_t p;
        p.packet_kind    = kind;
        p.payload_length = len[10:0];
        p.unit_count     = units[8:0];
        p.source_offset  = offset[13:0];
        p.prefix_byte0   = p0;
        p.prefix_byte1   = p1;
        p.prefix_byte2   = p2;
        p.marker         = mk;
        p.last_result    = 1'b0;
        pkt_batch.push_back(p);
    endfunction

    // Send whatever the aggregate holds; one unit goes out as a single NAL
    function automatic void flush_aggregate(logic mk);
        int strip;
        int len;
        if (agg_bytes != 0)
        begin
            if (agg_units == 1)
            begin
                strip = cfg_codec ? 4 : 3;
                len   = (agg_bytes > strip) ? agg_bytes - strip : 0;
                push_pkt(KIND_SINGLE, len, 0, 0, 8'd0, 8'd0, 8'd0, mk);
            end
            else if (cfg_codec)
                push_pkt(KIND_AGGR, agg_bytes, agg_units, 0, AP_TYPE, HEVC_PH_BYTE1, 8'd0, mk);
            else
                push_pkt(KIND_AGGR, agg_bytes, agg_units, 0, STAP_A_TYPE, 8'd0, 8'd0, mk);
        end
        agg_bytes = 0;
        agg_units = 0;
    endfunction

    // Packets caused by one NAL word, left in pkt_batch
    function automatic void packetize_nal(nal_word_t w);
        int         size;
        int         maxp;
        int         hdr;
        int         off;
        int         rem;
        int         chunk;
        logic       hevc;
        logic       start;
        logic       dropped;
        logic [7:0] p0;
        logic [7:0] fu;
        logic [7:0] f;

        pkt_batch.delete();
        size    = w.nal_size;
        if (size > MAX_NAL_BYTES)
            size = MAX_NAL_BYTES;
        maxp    = payload_limit();
        hevc    = cfg_codec;
        dropped = 1'b0;

        if (size <= maxp)
        begin
            hdr = hevc ? 2 : 1;
            if (agg_bytes + 2 + size > maxp)
                flush_aggregate(1'b0);
            if (agg_bytes + 2 + hdr + size <= maxp && !(!hevc && cfg_single))
            begin
                if (agg_bytes == 0)
                    agg_bytes = hdr;
                agg_bytes += 2 + size;
                if (agg_units < 511)
                    agg_units++;
            end
            else
            begin
                flush_aggregate(1'b0);
                push_pkt(KIND_SINGLE, size, 0, 0, 8'd0, 8'd0, 8'd0, w.last_in_frame);
            end
        end
        else
        begin
            flush_aggregate(1'b0);
            if (!hevc && cfg_single)
                dropped = 1'b1;
            else
            begin
                if (!hevc)
                begin
                    p0  = FU_A_TYPE | (w.header_byte0 & NRI_MASK);
                    fu  = w.header_byte0 & H264_TYPE_MASK;
                    hdr = 2;
                end
                else
                begin
                    p0  = HEVC_FU_TYPE;
                    fu  = (w.header_byte0 >> 1) & HEVC_TYPE_MASK;
                    hdr = 3;
                end
                off   = hdr - 1;
                rem   = size - off;
                chunk = maxp - hdr;
                start = 1'b1;
                // full size fragments
                while (rem + hdr > maxp)
                begin
                    f = fu | (start ? FU_START : 8'd0);
                    if (hevc)
                        push_pkt(KIND_FRAG, maxp, 0, off, p0, HEVC_PH_BYTE1, f, 1'b0);
                    else
                        push_pkt(KIND_FRAG, maxp, 0, off, p0, f, 8'd0, 1'b0);
                    off  += chunk;
                    rem  -= chunk;
                    start = 1'b0;
                end
                // closing fragment with the end bit
                f = fu | (start ? FU_START : 8'd0) | FU_END;
                if (hevc)
                    push_pkt(KIND_FRAG, rem + hdr, 0, off, p0, HEVC_PH_BYTE1, f,
                             w.last_in_frame);
                else
                    push_pkt(KIND_FRAG, rem + hdr, 0, off, p0, f, 8'd0, w.last_in_frame);
            end
        end

        if (!dropped && w.last_in_frame)
            flush_aggregate(1'b1);
        if (pkt_batch.size() > 0)
            pkt_batch[pkt_batch.size() - 1].last_result = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic stim_row_t nal_row(int size, logic [7:0] h0, logic [7:0] h1,
                                          logic last);
        stim_row_t r;
        r                  = '0;
        r.kind             = ROW_NAL;
        r.nal.nal_size     = size[13:0];
        r.nal.header_byte0 = h0;
        r.nal.header_byte1 = h1;
        r.nal.last_in_frame = last;
        return r;
    endfunction

    // A word whose only packet is a single NAL that can be read off directly
    function automatic stim_row_t single_row(int size, logic [7:0] h0, logic [7:0] h1,
                                             logic last, int exp_len, logic exp_mk);
        stim_row_t r;
        r                          = nal_row(size, h0, h1, last);
        r.typed                    = 1'b1;
        r.typed_pkt.packet_kind    = KIND_SINGLE;
        r.typed_pkt.payload_length = exp_len[10:0];
        r.typed_pkt.marker         = exp_mk;
        r.typed_pkt.last_result    = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [1:0] idx, logic [10:0] data);
        stim_row_t r;
        r           = '0;
        r.kind      = ROW_CFG;
        r.cfg_index = idx;
        r.cfg_data  = data;
        return r;
    endfunction

    // Write one register, then idle with cfg_we low before returning
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CODEC:       cfg_codec  = data[0];
            CFG_SINGLE_MODE: cfg_single = data[0];
            CFG_MAX_PAYLOAD: cfg_maxp   = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Stop offering and wait until every packet is out and the block is idle
    task automatic settle(input int extra);
        nal_ch.valid <= 1'b0;
        while (pkt_expected.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Offer one NAL word in bursts with random gaps; predict on acceptance
    task automatic send_nal(input nal_word_t w, input logic typed, input pkt_word_t typed_pkt);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                nal_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        nal_ch.valid         <= 1'b1;
        nal_ch.nal_size      <= w.nal_size;
        nal_ch.header_byte0  <= w.header_byte0;
        nal_ch.header_byte1  <= w.header_byte1;
        nal_ch.last_in_frame <= w.last_in_frame;
        @(posedge clk);
        while (nal_ch.ready !== 1'b1)
            @(posedge clk);
        packetize_nal(w);
        if (typed)
            pkt_expected.push_back(typed_pkt);
        else
            foreach (pkt_batch[i])
                pkt_expected.push_back(pkt_batch[i]);
    endtask

    function automatic string show_pkt(pkt_word_t p);
        return $sformatf("kind=%0d len=%0d units=%0d off=%0d pfx=%02h %02h %02h mk=%0b last=%0b",
                         p.packet_kind, p.payload_length, p.unit_count, p.source_offset,
                         p.prefix_byte0, p.prefix_byte1, p.prefix_byte2, p.marker,
                         p.last_result);
    endfunction

    // ---------------------------------------------------------------
    // Packet side: stall pattern, with one long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin : pkt_receiver
        int  hold_left;
        int  pat_left;
        int  pat_mode;
        bit  hold_taken;
        hold_left  = 0;
        pat_left   = 0;
        pat_mode   = 0;
        hold_taken = 0;
        pkt_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pkt_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_left  = HOLD_CYCLES - 1;
                pkt_ch.ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(16, 128);
                end
                pat_left--;
                case (pat_mode)
                    0:       pkt_ch.ready <= 1'b1;
                    1:       pkt_ch.ready <= 1'($urandom_range(0, 1));
                    2:       pkt_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: pkt_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Packet checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        pkt_word_t got;
        pkt_word_t want;
        if (rst_n && pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1)
        begin
            got.packet_kind    = pkt_ch.packet_kind;
            got.payload_length = pkt_ch.payload_length;
            got.unit_count     = pkt_ch.unit_count;
            got.source_offset  = pkt_ch.source_offset;
            got.prefix_byte0   = pkt_ch.prefix_byte0;
            got.prefix_byte1   = pkt_ch.prefix_byte1;
            got.prefix_byte2   = pkt_ch.prefix_byte2;
            got.marker         = pkt_ch.marker;
            got.last_result    = pkt_ch.last_result;
            if (pkt_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected packet word: %s", $realtime, show_pkt(got));
            end
            else
            begin
                want = pkt_expected.pop_front();
                if (got.packet_kind    !== want.packet_kind    ||
                    got.payload_length !== want.payload_length ||
                    got.unit_count     !== want.unit_count     ||
                    got.source_offset  !== want.source_offset  ||
                    got.prefix_byte0   !== want.prefix_byte0   ||
                    got.prefix_byte1   !== want.prefix_byte1   ||
                    got.prefix_byte2   !== want.prefix_byte2   ||
                    got.marker         !== want.marker         ||
                    got.last_result    !== want.last_result)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: packet mismatch\n  exp %s\n  got %s", $realtime,
                                 show_pkt(want), show_pkt(got));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : main_seq
        nal_word_t w;
        int        lim;
        int        size;
        int        sel;
        int        frame_len;
        int        phase;
        int        phase_len;
        int        phase_items;
        int        rand_items;
        logic [10:0] maxp_val;

        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        hold_req       = 0;
        cfg_codec      = 1'b0;
        cfg_single     = 1'b0;
        cfg_maxp       = PAYLOAD_RESET;
        agg_bytes      = 0;
        agg_units      = 0;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_CODEC;
        cfg_data             <= '0;
        nal_ch.valid         <= 1'b0;
        nal_ch.nal_size      <= '0;
        nal_ch.header_byte0  <= '0;
        nal_ch.header_byte1  <= '0;
        nal_ch.last_in_frame <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, starting from the reset settings
        dir_rows.push_back(single_row(1400, 8'hFF, 8'hFF, 1'b0, 1400, 1'b0));
        dir_rows.push_back(single_row(1, 8'h00, 8'h00, 1'b1, 1, 1'b1));
        // zero sized unit buffered alone, then flushed by the largest unit
        dir_rows.push_back(nal_row(0, 8'h65, 8'h00, 1'b0));
        dir_rows.push_back(nal_row(16383, 8'hFF, 8'hFF, 1'b1));
        // STAP-A of three, closed by the frame end
        dir_rows.push_back(nal_row(100, 8'h41, 8'h00, 1'b0));
        dir_rows.push_back(nal_row(100, 8'h41, 8'h00, 1'b0));
        dir_rows.push_back(nal_row(100, 8'h01, 8'h00, 1'b1));
        // payload limit below range clamps to 300
        dir_rows.push_back(cfg_row(CFG_MAX_PAYLOAD, 11'd0));
        dir_rows.push_back(single_row(300, 8'h65, 8'h00, 1'b1, 300, 1'b1));
        dir_rows.push_back(nal_row(301, 8'h7C, 8'h00, 1'b1));
        // payload limit above range clamps to 1500
        dir_rows.push_back(cfg_row(CFG_MAX_PAYLOAD, 11'h7FF));
        dir_rows.push_back(nal_row(1501, 8'h5C, 8'h00, 1'b0));
        // HEVC fragments and AP
        dir_rows.push_back(cfg_row(CFG_CODEC, 11'd1));
        dir_rows.push_back(nal_row(5000, 8'h26, 8'h01, 1'b0));
        dir_rows.push_back(nal_row(200, 8'h40, 8'h01, 1'b0));
        dir_rows.push_back(nal_row(200, 8'h42, 8'h01, 1'b1));
        // codec switched under a buffered unit: strip exceeds the buffer
        dir_rows.push_back(cfg_row(CFG_CODEC, 11'd0));
        dir_rows.push_back(nal_row(0, 8'h06, 8'h00, 1'b0));
        dir_rows.push_back(cfg_row(CFG_CODEC, 11'd1));
        dir_rows.push_back(nal_row(2000, 8'h02, 8'h01, 1'b0));
        // H.264 mode 0: no aggregation, oversized unit dropped
        dir_rows.push_back(cfg_row(CFG_CODEC, 11'd0));
        dir_rows.push_back(cfg_row(CFG_SINGLE_MODE, 11'd1));
        dir_rows.push_back(single_row(50, 8'h67, 8'h00, 1'b1, 50, 1'b1));
        dir_rows.push_back(nal_row(40, 8'h68, 8'h00, 1'b0));
        dir_rows.push_back(nal_row(3000, 8'h65, 8'h00, 1'b1));
        // mode 0 has no effect on HEVC
        dir_rows.push_back(cfg_row(CFG_CODEC, 11'd1));
        dir_rows.push_back(nal_row(3000, 8'h2A, 8'h01, 1'b0));
        dir_rows.push_back(nal_row(10, 8'h02, 8'h01, 1'b0));
        dir_rows.push_back(nal_row(10, 8'h02, 8'h01, 1'b1));
        // unused index, then back to reset settings
        dir_rows.push_back(cfg_row(2'd3, 11'h7FF));
        dir_rows.push_back(cfg_row(CFG_CODEC, 11'd0));
        dir_rows.push_back(cfg_row(CFG_SINGLE_MODE, 11'd0));
        dir_rows.push_back(cfg_row(CFG_MAX_PAYLOAD, PAYLOAD_RESET));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle(SETTLE_CYCLES);
                write_reg(dir_rows[i].cfg_index, dir_rows[i].cfg_data);
            end
            else
                send_nal(dir_rows[i].nal, dir_rows[i].typed, dir_rows[i].typed_pkt);
        end

        // Random phases: fresh settings each phase, words grouped into frames
        phase      = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            settle(SETTLE_CYCLES);
            write_reg(CFG_CODEC, 11'($urandom_range(0, 1)));
            write_reg(CFG_SINGLE_MODE, 11'($urandom_range(0, 3) == 0));
            case ($urandom_range(0, 5))
                0:       maxp_val = PAYLOAD_MIN;
                1:       maxp_val = PAYLOAD_MAX;
                2:       maxp_val = 11'($urandom_range(0, 299));
                3:       maxp_val = 11'($urandom_range(1501, 2047));
                default: maxp_val = 11'($urandom_range(300, 1500));
            endcase
            write_reg(CFG_MAX_PAYLOAD, maxp_val);
            lim = payload_limit();
            // long receiver hold-off while words keep coming
            if (phase == 1)
                hold_req = 1;
            phase_len   = $urandom_range(20, 50);
            phase_items = 0;
            while (phase_items < phase_len)
            begin
                frame_len = $urandom_range(1, 6);
                for (int u = 0; u < frame_len; u++)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 2)
                        size = 0;
                    else if (sel < 60)
                        size = $urandom_range(1, lim / 4);
                    else if (sel < 80)
                        size = $urandom_range(lim / 4 + 1, lim);
                    else if (sel < 96)
                        size = $urandom_range(lim + 1, 3 * lim);
                    else
                        size = $urandom_range(lim + 1, MAX_NAL_BYTES);
                    w.nal_size      = size[13:0];
                    w.header_byte0  = 8'($urandom_range(0, 255));
                    w.header_byte1  = 8'($urandom_range(0, 255));
                    w.last_in_frame = (u == frame_len - 1);
                    // some broken frames
                    if ($urandom_range(0, 9) == 0)
                        w.last_in_frame = 1'($urandom_range(0, 1));
                    send_nal(w, 1'b0, '0);
                    phase_items++;
                    rand_items++;
                end
            end
            phase++;
        end

        // Long run of zero sized units gathered into one aggregate
        settle(SETTLE_CYCLES);
        write_reg(CFG_CODEC, 11'd0);
        write_reg(CFG_SINGLE_MODE, 11'd0);
        write_reg(CFG_MAX_PAYLOAD, PAYLOAD_MAX);
        for (int k = 0; k <= FILL_ITEMS + 1; k++)
        begin
            w.nal_size      = '0;
            w.header_byte0  = 8'($urandom_range(0, 255));
            w.header_byte1  = 8'($urandom_range(0, 255));
            w.last_in_frame = (k == 0 || k == FILL_ITEMS + 1);
            send_nal(w, 1'b0, '0);
        end

        // Drain and finish
        settle(SETTLE_CYCLES * 4);
        if (mismatch_count == 0 && pkt_expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
